/* rtl/tlos_pkg.sv */
// Shared types and constants of the terrain line-of-sight unit.
`timescale 1ns / 1ps
package tlos_pkg;

  localparam int unsigned VAL_W     = 24;  // Q16.8 field width
  localparam int unsigned DIV_W     = 28;  // dividend width of the shared divider
  localparam int unsigned DIV_STEPS = 28;  // one quotient bit per cycle
  localparam int unsigned SQ_STEPS  = 25;  // one root bit per cycle
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned IN_DATA_W = 184;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LEN  = 2'd2;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Axis selectors for the per-axis divisions and walk accumulators
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;
  localparam logic [1:0] AX_L = 2'd3;

  typedef struct packed {
    logic       clr;
    logic       wr;
    logic       load;
    logic       sq_mul;
    logic       sq_init;
    logic       sq_step;
    logic       div_init;
    logic       div_n;
    logic       div_step;
    logic       n_store;
    logic       ax_store;
    logic [1:0] ax_sel;
    logic       walk_init;
    logic       walk;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hit;
  } sts_t;

endpackage

/* rtl/tlos_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module tlos_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tlos_dp.sv */
// Datapath: registers, square root, shared divider, sample walk pipeline.
`timescale 1ns / 1ps
module tlos_dp #(
  parameter int unsigned ROWS      = 64,
  parameter int unsigned COLS      = 64,
  parameter int unsigned MAX_STEPS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tlos_pkg::cmd_t                      cmd_i,
  output tlos_pkg::sts_t                      sts_o,
  input  logic                                cfg_we_i,
  input  logic [tlos_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [tlos_pkg::VAL_W-1:0]          cfg_wdata_i,
  input  logic [tlos_pkg::IN_DATA_W-1:0]      in_data_i,
  output logic [tlos_pkg::OUT_DATA_W-1:0]     out_data_o
);

  localparam int unsigned DEPTH = ROWS * COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned NW    = $clog2(MAX_STEPS + 1);

  // configuration
  logic [23:0] row_scale_q, col_scale_q, step_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_scale_q <= 24'd256;
      col_scale_q <= 24'd256;
      step_len_q  <= 24'd25600;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        tlos_pkg::CFG_ROW_SCALE: row_scale_q <= cfg_wdata_i;
        tlos_pkg::CFG_COL_SCALE: col_scale_q <= cfg_wdata_i;
        tlos_pkg::CFG_STEP_LEN:  step_len_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input fields
  logic [5:0]  cell_row, cell_col;
  logic [23:0] cell_height, from_x, from_y, from_z, to_x, to_y, to_z;
  assign cell_row    = in_data_i[5:0];
  assign cell_col    = in_data_i[11:6];
  assign cell_height = in_data_i[35:12];
  assign from_x      = in_data_i[59:36];
  assign from_y      = in_data_i[83:60];
  assign from_z      = in_data_i[107:84];
  assign to_x        = in_data_i[131:108];
  assign to_y        = in_data_i[155:132];
  assign to_z        = in_data_i[179:156];

  // capture end points and differences
  logic signed [23:0] fx_q, fy_q, fz_q;
  logic signed [24:0] dx_q, dy_q, dz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fx_q <= from_x;
      fy_q <= from_y;
      fz_q <= from_z;
      dx_q <= $signed({to_x[23], to_x}) - $signed({from_x[23], from_x});
      dy_q <= $signed({to_y[23], to_y}) - $signed({from_y[23], from_y});
      dz_q <= $signed({to_z[23], to_z}) - $signed({from_z[23], from_z});
    end
  end

  // squares, then their sum as radicand
  logic signed [49:0] sqx_w, sqy_w, sqz_w;
  logic [48:0] sqx_q, sqy_q, sqz_q;
  assign sqx_w = dx_q * dx_q;
  assign sqy_w = dy_q * dy_q;
  assign sqz_w = dz_q * dz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_mul) begin
      sqx_q <= sqx_w[48:0];
      sqy_q <= sqy_w[48:0];
      sqz_q <= sqz_w[48:0];
    end
  end

  // digit-by-digit square root, one root bit a cycle
  logic [49:0] rad_q;
  logic [24:0] root_q;
  logic [26:0] srem_q;
  logic [28:0] srem_t, strial;
  logic        sge;
  assign srem_t = {srem_q, rad_q[49:48]};
  assign strial = {2'b00, root_q, 2'b01};
  assign sge    = srem_t >= strial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_init) begin
      rad_q  <= 50'(sqx_q) + 50'(sqy_q) + 50'(sqz_q);
      root_q <= '0;
      srem_q <= '0;
    end else if (cmd_i.sq_step) begin
      rad_q  <= {rad_q[47:0], 2'b00};
      root_q <= {root_q[23:0], sge};
      srem_q <= sge ? 27'(srem_t - strial) : srem_t[26:0];
    end
  end

  // shared restoring divider
  logic [23:0] step_eff;
  logic [tlos_pkg::DIV_W-1:0] dvd_q;
  logic [24:0] dvs_q, drem_q;
  logic [25:0] dpart;
  logic        dge;
  logic [NW-1:0] nsteps_q;
  logic [tlos_pkg::DIV_W-1:0] dvd_sel;
  assign step_eff = (step_len_q == 24'd0) ? 24'd1 : step_len_q;
  assign dpart    = {drem_q, dvd_q[tlos_pkg::DIV_W-1]};
  assign dge      = dpart >= {1'b0, dvs_q};

  always_comb begin
    case (cmd_i.ax_sel)
      tlos_pkg::AX_X: dvd_sel = dx_q[24] ? 28'(-dx_q) : 28'(dx_q);
      tlos_pkg::AX_Y: dvd_sel = dy_q[24] ? 28'(-dy_q) : 28'(dy_q);
      tlos_pkg::AX_Z: dvd_sel = dz_q[24] ? 28'(-dz_q) : 28'(dz_q);
      default:        dvd_sel = 28'(root_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      drem_q <= '0;
      if (cmd_i.div_n) begin
        dvd_q <= 28'({step_eff, 2'b00}) + 28'(step_eff) + 28'({root_q, 1'b0});
        dvs_q <= {step_eff, 1'b0};
      end else begin
        dvd_q <= dvd_sel;
        dvs_q <= 25'(nsteps_q);
      end
    end else if (cmd_i.div_step) begin
      dvd_q  <= {dvd_q[tlos_pkg::DIV_W-2:0], dge};
      drem_q <= dge ? 25'(dpart - {1'b0, dvs_q}) : dpart[24:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.n_store) begin
      nsteps_q <= (dvd_q > 28'(MAX_STEPS)) ? NW'(MAX_STEPS) : dvd_q[NW-1:0];
    end
  end

  // floor quotient and non-negative remainder per axis
  logic signed [26:0] qb_q [4];
  logic [NW-1:0]      rb_q [4];
  logic [25:0]        qpos;
  logic [NW-1:0]      rrem;
  logic               dneg;
  assign qpos = {1'b0, dvd_q[24:0]};
  assign rrem = drem_q[NW-1:0];

  always_comb begin
    case (cmd_i.ax_sel)
      tlos_pkg::AX_X: dneg = dx_q[24];
      tlos_pkg::AX_Y: dneg = dy_q[24];
      tlos_pkg::AX_Z: dneg = dz_q[24];
      default:        dneg = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ax_store) begin
      if (!dneg) begin
        qb_q[cmd_i.ax_sel] <= $signed({1'b0, qpos});
        rb_q[cmd_i.ax_sel] <= rrem;
      end else if (rrem != '0) begin
        qb_q[cmd_i.ax_sel] <= -$signed(27'(qpos) + 27'd1);
        rb_q[cmd_i.ax_sel] <= nsteps_q - rrem;
      end else begin
        qb_q[cmd_i.ax_sel] <= -$signed({1'b0, qpos});
        rb_q[cmd_i.ax_sel] <= '0;
      end
    end
  end

  // walk: accumulate floor(n*D/N) incrementally
  logic signed [26:0] acc_q [4];
  logic [NW-1:0]      accr_q [4];
  logic [NW-1:0]      n_q;
  logic               issued_q, issue, last;
  assign issue = cmd_i.walk && !issued_q;
  assign last  = n_q == nsteps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issued_q <= 1'b1;
      n_q      <= '0;
    end else if (cmd_i.walk_init) begin
      issued_q <= 1'b0;
      n_q      <= '0;
    end else if (issue) begin
      if (last) begin
        issued_q <= 1'b1;
      end else begin
        n_q <= n_q + NW'(1);
      end
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_acc
    logic [NW:0] rsum;
    logic        carry;
    assign rsum  = {1'b0, accr_q[i]} + {1'b0, rb_q[i]};
    assign carry = rsum >= {1'b0, nsteps_q};
    always_ff @(posedge clk_i) begin
      if (cmd_i.walk_init) begin
        acc_q[i]  <= '0;
        accr_q[i] <= '0;
      end else if (issue) begin
        acc_q[i]  <= acc_q[i] + qb_q[i] + $signed({26'd0, carry});
        accr_q[i] <= carry ? NW'(rsum - {1'b0, nsteps_q}) : rsum[NW-1:0];
      end
    end
  end

  // stage 1: scale to grid coordinates
  logic signed [26:0] sx_w, sy_w, sz_w;
  logic signed [24:0] xs, ys;
  logic               p1_v_q, p1_last_q;
  logic signed [49:0] rprod_q, cprod_q;
  logic signed [24:0] p1_z_q;
  logic [25:0]        p1_dist_q;
  assign sx_w = $signed({{3{fx_q[23]}}, fx_q}) + acc_q[0];
  assign sy_w = $signed({{3{fy_q[23]}}, fy_q}) + acc_q[1];
  assign sz_w = $signed({{3{fz_q[23]}}, fz_q}) + acc_q[2];
  assign xs   = sx_w[24:0];
  assign ys   = sy_w[24:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else begin
      p1_v_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rprod_q   <= xs * $signed({1'b0, row_scale_q});
      cprod_q   <= ys * $signed({1'b0, col_scale_q});
      p1_z_q    <= sz_w[24:0];
      p1_dist_q <= acc_q[3][25:0];
      p1_last_q <= last;
    end
  end

  // stage 2: grid range check and height read
  logic signed [33:0] rr, cc;
  logic               off_w;
  logic [20:0]        rd_addr_w, wr_addr_w;
  logic               p2_v_q, p2_off_q, p2_last_q;
  logic signed [24:0] p2_z_q;
  logic [25:0]        p2_dist_q;
  logic [23:0]        h_rd;
  logic               cell_ok, ram_we;
  logic [AW-1:0]      clr_q;

  assign rr    = rprod_q[49:16];
  assign cc    = cprod_q[49:16];
  assign off_w = rr[33] || cc[33] || (rr >= $signed(34'(ROWS)))
                 || (cc >= $signed(34'(COLS)));
  assign rd_addr_w = 21'(rr[RW-1:0]) * 21'(COLS) + 21'(cc[CW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else begin
      p2_v_q <= cmd_i.walk && p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_off_q  <= off_w;
    p2_z_q    <= p1_z_q;
    p2_dist_q <= p1_dist_q;
    p2_last_q <= p1_last_q;
  end

  // height store: clear sweep or cell write
  assign cell_ok   = (11'(cell_row) < 11'(ROWS)) && (11'(cell_col) < 11'(COLS));
  assign wr_addr_w = 21'(cell_row) * 21'(COLS) + 21'(cell_col);
  assign ram_we    = cmd_i.clr || (cmd_i.wr && cell_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  tlos_ram #(
    .WIDTH(tlos_pkg::VAL_W),
    .DEPTH(DEPTH)
  ) u_heights (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cmd_i.clr ? clr_q : wr_addr_w[AW-1:0]),
    .wdata_i(cmd_i.clr ? 24'd0 : cell_height),
    .raddr_i(rd_addr_w[AW-1:0]),
    .rdata_o(h_rd)
  );

  // stage 3: decide
  logic below, hit;
  logic res_vis_q, res_off_q;
  logic [23:0] res_dist_q;
  logic out_vis_q, out_off_q;
  logic [23:0] out_dist_q;
  assign below = p2_z_q < $signed({h_rd[23], h_rd});
  assign hit   = cmd_i.walk && p2_v_q && (p2_off_q || below || p2_last_q);

  always_ff @(posedge clk_i) begin
    if (hit) begin
      res_vis_q  <= !(p2_off_q || below);
      res_off_q  <= p2_off_q;
      res_dist_q <= (|p2_dist_q[25:24]) ? 24'hFFFFFF : p2_dist_q[23:0];
    end
    if (cmd_i.out_load) begin
      out_vis_q  <= res_vis_q;
      out_off_q  <= res_off_q;
      out_dist_q <= res_dist_q;
    end
  end

  assign sts_o.clr_last = clr_q == AW'(DEPTH - 1);
  assign sts_o.hit      = hit;
  assign out_data_o     = {6'd0, out_dist_q, out_off_q, out_vis_q};

endmodule

/* rtl/tlos_ctrl.sv */
// Controller: sequences clear sweep, root, divisions, walk and output.
`timescale 1ns / 1ps
module tlos_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  input  logic           s_tuser_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  output tlos_pkg::cmd_t cmd_o,
  input  tlos_pkg::sts_t sts_i
);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_SQR  = 4'd2;
  localparam logic [3:0] ST_SUM  = 4'd3;
  localparam logic [3:0] ST_ROOT = 4'd4;
  localparam logic [3:0] ST_DIVN = 4'd5;
  localparam logic [3:0] ST_DIVA = 4'd6;
  localparam logic [3:0] ST_WALK = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  localparam logic [tlos_pkg::CNT_W-1:0] DIV_LAST =
    tlos_pkg::CNT_W'(tlos_pkg::DIV_STEPS);
  localparam logic [tlos_pkg::CNT_W-1:0] SQ_LAST =
    tlos_pkg::CNT_W'(tlos_pkg::SQ_STEPS - 1);

  logic [3:0] state_q, state_d;
  logic [tlos_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0] sel_q, sel_d;
  logic mv_q, mv_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    mv_d    = mv_q && !m_tready_i;
    case (state_q)
      ST_CLR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid_i) begin
          if (s_tuser_i == tlos_pkg::ACT_QUERY) begin
            cmd_o.load = 1'b1;
            state_d    = ST_SQR;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      ST_SQR: begin
        cmd_o.sq_mul = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sq_init = 1'b1;
        cnt_d         = '0;
        state_d       = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.sq_step = 1'b1;
        if (cnt_q == SQ_LAST) begin
          cnt_d   = '0;
          state_d = ST_DIVN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DIVN: begin
        cmd_o.div_n = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == '0) begin
          cmd_o.div_init = 1'b1;
        end else if (cnt_q <= DIV_LAST) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.n_store = 1'b1;
          cnt_d         = '0;
          sel_d         = tlos_pkg::AX_X;
          state_d       = ST_DIVA;
        end
      end
      ST_DIVA: begin
        cmd_o.ax_sel = sel_q;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == '0) begin
          cmd_o.div_init = 1'b1;
        end else if (cnt_q <= DIV_LAST) begin
          cmd_o.div_step = 1'b1;
        end else begin
          cmd_o.ax_store = 1'b1;
          cnt_d          = '0;
          if (sel_q == tlos_pkg::AX_L) begin
            cmd_o.walk_init = 1'b1;
            state_d         = ST_WALK;
          end else begin
            sel_d = sel_q + 1'b1;
          end
        end
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (sts_i.hit) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!mv_q || m_tready_i) begin
          cmd_o.out_load = 1'b1;
          mv_d           = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      cnt_q   <= '0;
      sel_q   <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      mv_q    <= mv_d;
    end
  end

  assign s_tready_o = state_q == ST_IDLE;
  assign m_tvalid_o = mv_q;

  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!mv_q || m_tready_i))
    else $error("result loaded over an untaken result");

  a_root_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT) |-> (cnt_q <= SQ_LAST))
    else $error("root iteration count overran");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVN || state_q == ST_DIVA) |-> (cnt_q <= DIV_LAST + 1'b1))
    else $error("divider iteration count overran");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR && state_d != ST_CLR) |-> sts_i.clr_last)
    else $error("clear sweep left early");

endmodule

/* rtl/terrain_line_of_sight_unit.sv */
// Sequence: a write item is stored from idle; a query runs capture, squares, root, the
// five divides, a walk over at most N+1 samples (N at most MAX_STEPS) and the output.
// Throughput: one query at a time; the walk samples one point a cycle, bounded by
// the single height-store read port; the 25-bit root and five 28-bit divides run
// one bit a cycle on shared units. Write items are taken every cycle when idle.
// Reset: asynchronous, active low; control and configuration registers return to defaults
// and a clear sweep zeroes the height store, during which no item is accepted.
`timescale 1ns / 1ps
module terrain_line_of_sight_unit #(
  parameter int unsigned ROWS      = 64,
  parameter int unsigned COLS      = 64,
  parameter int unsigned MAX_STEPS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, low bit up: cell_row[6], cell_col[6], cell_height[24], from_x[24],
  // from_y[24], from_z[24], to_x[24], to_y[24], to_z[24], zero pad[4]
  input  logic [tlos_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: action (0 write cell, 1 query)
  input  logic                                s_axis_tuser,
  // result out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata, low bit up: visible[1], off_grid[1], walked_distance[24], zero pad[6]
  output logic [tlos_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // configuration write
  input  logic                                cfg_we_i,
  input  logic [tlos_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [tlos_pkg::VAL_W-1:0]          cfg_wdata_i
);

  tlos_pkg::cmd_t cmd;
  tlos_pkg::sts_t sts;

  // Sequence the query: capture, squares, root, step count, per-axis divides, walk.
  tlos_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_axis_tvalid),
    .s_tuser_i (s_axis_tuser),
    .s_tready_o(s_axis_tready),
    .m_tvalid_o(m_axis_tvalid),
    .m_tready_i(m_axis_tready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  // Hold the arithmetic, the height store and the result register.
  tlos_dp #(
    .ROWS     (ROWS),
    .COLS     (COLS),
    .MAX_STEPS(MAX_STEPS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

endmodule
